// ----- hw/rtl/dmtc_pkg.sv -----
// Package for the direct-mapped tile cache: word types, slot layout,
// result kinds, register indexes and the sequencer state type. No dependencies.
package dmtc_pkg;

	localparam int INDEX_BITS  = 6;
	localparam int FINITE_EDGE = 15;
	localparam int COORD_W     = 32;
	localparam int TAG_W       = COORD_W - INDEX_BITS;
	localparam int ADDR_W      = 2 * INDEX_BITS;
	localparam int SLOTS       = 1 << ADDR_W;

	// result kinds
	localparam logic [2:0] KIND_EMPTY = 3'd0;
	localparam logic [2:0] KIND_HIT   = 3'd1;
	localparam logic [2:0] KIND_LOAD  = 3'd2;
	localparam logic [2:0] KIND_GEN   = 3'd3;
	localparam logic [2:0] KIND_SAVE  = 3'd4;
	localparam logic [2:0] KIND_DECO  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_FINITE  = 2'd0;
	localparam logic [1:0] CFG_STORAGE = 2'd1;
	localparam logic [1:0] CFG_GEN     = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] tile_x;
		logic signed [COORD_W-1:0] tile_z;
		logic                      storage_hit;
		logic                      stored_decorated;
	} req_t;

	typedef struct packed {
		logic [2:0]                kind;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_z;
		logic                      last;
	} rsp_t;

	typedef struct packed {
		logic finite_world;
		logic storage_present;
		logic generator_present;
	} cfg_t;

	// queue entry: request plus its classification
	typedef struct packed {
		req_t req;
		logic insq;
	} qent_t;

	typedef struct packed {
		logic             valid;
		logic             dec;
		logic [TAG_W-1:0] tx;
		logic [TAG_W-1:0] tz;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_SELF, S_SAVE, S_NB, S_DEC, S_MAIN, S_DW
	} state_t;

	// tile lies inside the finite square (or the world is unbounded)
	function automatic logic in_sq(input logic finite, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] z);
		logic [COORD_W-1:0] edge_c;
		edge_c = COORD_W'(FINITE_EDGE);
		return !finite || (x <= edge_c && z <= edge_c);
	endfunction

endpackage

// ----- hw/rtl/dmtc_front.sv -----
// Front end of the tile cache: accepts request words, classifies them
// against the finite square and queues them. Depends on dmtc_pkg.
module dmtc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmtc_pkg::cfg_t        cfg,
	input  logic                  clearing,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  dmtc_pkg::req_t        req,
	output logic                  q_valid,
	output dmtc_pkg::qent_t       q_data,
	input  logic                  q_pop
);

	dmtc_pkg::qent_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	assign req_ready = (cnt_q != 2'd2) && !clearing;
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_data    = ent_q[rd_ptr_q];

	// queue storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].req  <= req;
			ent_q[wr_ptr_q].insq <= dmtc_pkg::in_sq(cfg.finite_world, req.tile_x, req.tile_z);
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ----- hw/rtl/dmtc_back.sv -----
// Back end of the tile cache: slot memory, clearing pass and the sequencer
// that resolves misses, neighbour checks and decoration. Depends on dmtc_pkg.
module dmtc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dmtc_pkg::cfg_t        cfg,
	output logic                  clearing,
	input  logic                  q_valid,
	input  dmtc_pkg::qent_t       q_data,
	output logic                  q_pop,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output dmtc_pkg::rsp_t        rsp
);

	localparam int AW = dmtc_pkg::ADDR_W;
	localparam int IB = dmtc_pkg::INDEX_BITS;
	localparam int TW = dmtc_pkg::TAG_W;
	localparam int CW = dmtc_pkg::COORD_W;

	dmtc_pkg::state_t st_q, st_d;
	dmtc_pkg::req_t   item_q;
	logic [AW-1:0]    clr_addr_q;
	logic [3:0]       cnt_q;
	logic [1:0]       j_q;
	logic [2:0]       kind_q;
	logic             newdec_q;
	logic             save_q;
	logic [TW-1:0]    ev_tx_q, ev_tz_q;
	logic [7:0]       pres_q, decok_q;
	logic [3:0]       mask_q;
	logic             nb_ok_q;
	logic [TW-1:0]    nb_tx_q, nb_tz_q;

	// memory
	dmtc_pkg::slot_t  mem [dmtc_pkg::SLOTS];
	dmtc_pkg::slot_t  rdata_q;
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_addr;
	dmtc_pkg::slot_t  mem_wdata;

	// output register
	logic             out_valid_q;
	dmtc_pkg::rsp_t   out_q;
	logic             out_free, out_load;
	dmtc_pkg::rsp_t   out_d;

	// next-value helpers
	logic [CW-1:0]    x, z, xp, xm, zp, zm, nx, nz, tgx, tgz;
	logic             self_hit, nb_hit, new_valid, new_dec;
	logic [2:0]       new_kind;
	logic [3:0]       mask_new, mask_rest;
	logic [3:0]       j_bit;
	logic             gen;

	assign gen       = cfg.generator_present;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign clearing  = (st_q == dmtc_pkg::S_CLR);

	assign x  = item_q.tile_x;
	assign z  = item_q.tile_z;
	assign xp = x + 1'b1;
	assign xm = x - 1'b1;
	assign zp = z + 1'b1;
	assign zm = z - 1'b1;

	// neighbour coordinates by read slot
	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin nx = xp; nz = zp; end
			3'd1: begin nx = x;  nz = zp; end
			3'd2: begin nx = xp; nz = z;  end
			3'd3: begin nx = xm; nz = z;  end
			3'd4: begin nx = xm; nz = zp; end
			3'd5: begin nx = x;  nz = zm; end
			3'd6: begin nx = xp; nz = zm; end
			default: begin nx = xm; nz = zm; end
		endcase
	end

	// decoration targets: self, left, below, below-left
	always_comb begin
		case (j_q)
			2'd0: begin tgx = x;  tgz = z;  end
			2'd1: begin tgx = xm; tgz = z;  end
			2'd2: begin tgx = x;  tgz = zm; end
			default: begin tgx = xm; tgz = zm; end
		endcase
	end

	assign self_hit = rdata_q.valid && rdata_q.tx == x[CW-1:IB] && rdata_q.tz == z[CW-1:IB];
	assign nb_hit   = rdata_q.valid && rdata_q.tx == nb_tx_q && rdata_q.tz == nb_tz_q;

	// miss resolution
	always_comb begin
		if (cfg.storage_present && item_q.storage_hit) begin
			new_kind  = dmtc_pkg::KIND_LOAD;
			new_valid = 1'b1;
			new_dec   = item_q.stored_decorated;
		end else if (gen) begin
			new_kind  = dmtc_pkg::KIND_GEN;
			new_valid = 1'b1;
			new_dec   = 1'b0;
		end else begin
			new_kind  = dmtc_pkg::KIND_EMPTY;
			new_valid = 1'b0;
			new_dec   = 1'b0;
		end
	end

	// completed 2x2 blocks
	assign mask_new[0] = !newdec_q && pres_q[0] && pres_q[1] && pres_q[2];
	assign mask_new[1] = pres_q[3] && pres_q[4] && pres_q[1] && decok_q[3];
	assign mask_new[2] = pres_q[5] && pres_q[6] && pres_q[2] && decok_q[5];
	assign mask_new[3] = pres_q[7] && pres_q[3] && pres_q[5] && decok_q[7];

	assign j_bit     = 4'b0001 << j_q;
	assign mask_rest = mask_q & ~j_bit;

	// sequencer next state and outputs
	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {q_data.req.tile_z[IB-1:0], q_data.req.tile_x[IB-1:0]};
		mem_wdata = '0;
		out_load  = 1'b0;
		out_d     = '0;
		case (st_q)
			dmtc_pkg::S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
				if (clr_addr_q == {AW{1'b1}})
					st_d = dmtc_pkg::S_IDLE;
			end
			dmtc_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_data.insq) begin
						mem_re = 1'b1;
						st_d   = dmtc_pkg::S_SELF;
					end else begin
						st_d = dmtc_pkg::S_MAIN;
					end
				end
			end
			dmtc_pkg::S_SELF: begin
				mem_addr = {z[IB-1:0], x[IB-1:0]};
				if (self_hit) begin
					st_d = dmtc_pkg::S_MAIN;
				end else begin
					mem_we = 1'b1;
					if (new_valid)
						mem_wdata = '{valid: 1'b1, dec: new_dec, tx: x[CW-1:IB], tz: z[CW-1:IB]};
					if (rdata_q.valid && cfg.storage_present)
						st_d = dmtc_pkg::S_SAVE;
					else if (new_valid)
						st_d = dmtc_pkg::S_NB;
					else
						st_d = dmtc_pkg::S_MAIN;
				end
			end
			dmtc_pkg::S_SAVE: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{kind: dmtc_pkg::KIND_SAVE, out_x: {ev_tx_q, x[IB-1:0]},
						out_z: {ev_tz_q, z[IB-1:0]}, last: 1'b0};
					st_d = (kind_q != dmtc_pkg::KIND_EMPTY) ? dmtc_pkg::S_NB : dmtc_pkg::S_MAIN;
				end
			end
			dmtc_pkg::S_NB: begin
				mem_addr = {nz[IB-1:0], nx[IB-1:0]};
				mem_re   = !cnt_q[3];
				if (cnt_q[3])
					st_d = dmtc_pkg::S_DEC;
			end
			dmtc_pkg::S_DEC: begin
				st_d = dmtc_pkg::S_MAIN;
			end
			dmtc_pkg::S_MAIN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{kind: kind_q, out_x: x, out_z: z,
						last: (mask_q & {4{gen}}) == 4'd0};
					st_d = (mask_q == 4'd0) ? dmtc_pkg::S_IDLE : dmtc_pkg::S_DW;
				end
			end
			dmtc_pkg::S_DW: begin
				mem_addr = {tgz[IB-1:0], tgx[IB-1:0]};
				if (!mask_q[j_q]) begin
					if (j_q == 2'd3)
						st_d = dmtc_pkg::S_IDLE;
				end else if (!gen || out_free) begin
					mem_we    = 1'b1;
					mem_wdata = '{valid: 1'b1, dec: 1'b1, tx: tgx[CW-1:IB], tz: tgz[CW-1:IB]};
					out_load  = gen;
					out_d     = '{kind: dmtc_pkg::KIND_DECO, out_x: tgx, out_z: tgz,
						last: mask_rest == 4'd0};
					if (mask_rest == 4'd0 || j_q == 2'd3)
						st_d = dmtc_pkg::S_IDLE;
				end
			end
			default: st_d = dmtc_pkg::S_IDLE;
		endcase
	end

	// slot memory, one port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_addr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= dmtc_pkg::S_CLR;
		else
			st_q <= st_d;
	end

	// control counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			cnt_q       <= '0;
			j_q         <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == dmtc_pkg::S_CLR)
				clr_addr_q <= clr_addr_q + 1'b1;
			if (st_q == dmtc_pkg::S_NB)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (st_q == dmtc_pkg::S_IDLE || st_q == dmtc_pkg::S_SELF)
				mask_q <= '0;
			else if (st_q == dmtc_pkg::S_DEC)
				mask_q <= mask_new;
			else if (st_q == dmtc_pkg::S_DW && mem_we)
				mask_q <= mask_rest;
			if (st_q == dmtc_pkg::S_DW && st_d == st_q && (mem_we || !mask_q[j_q]))
				j_q <= j_q + 1'b1;
			else if (st_q != dmtc_pkg::S_DW)
				j_q <= '0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_d;
		if (q_pop) begin
			item_q <= q_data.req;
			kind_q <= dmtc_pkg::KIND_EMPTY;
		end
		if (st_q == dmtc_pkg::S_SELF) begin
			kind_q   <= self_hit ? dmtc_pkg::KIND_HIT : new_kind;
			newdec_q <= new_dec;
			save_q   <= rdata_q.valid && cfg.storage_present;
			ev_tx_q  <= rdata_q.tx;
			ev_tz_q  <= rdata_q.tz;
		end
		if (st_q == dmtc_pkg::S_NB) begin
			nb_ok_q <= dmtc_pkg::in_sq(cfg.finite_world, nx, nz);
			nb_tx_q <= nx[CW-1:IB];
			nb_tz_q <= nz[CW-1:IB];
			if (cnt_q != 4'd0) begin
				pres_q[cnt_q[2:0] - 3'd1]  <= !nb_ok_q || nb_hit;
				decok_q[cnt_q[2:0] - 3'd1] <= nb_ok_q && nb_hit && !rdata_q.dec;
			end
		end
	end

	// checks
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == dmtc_pkg::S_CLR |-> !q_pop) else $error("queue popped during clear");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("output overwritten");
	a_hit_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.kind == dmtc_pkg::KIND_HIT |-> out_d.last)
		else $error("hit not last");
	a_save_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_d.kind == dmtc_pkg::KIND_SAVE |-> !out_d.last && save_q)
		else $error("bad save word");

endmodule

// ----- hw/rtl/direct_mapped_tile_cache_unit.sv -----
// Top level of the direct-mapped tile cache: configuration registers,
// front queue and back sequencer. Depends on dmtc_pkg, dmtc_front, dmtc_back.
//
//  channel | signals                        | direction
//  req     | req_valid, req_ready, req      | in  (request word)
//  rsp     | rsp_valid, rsp_ready, rsp      | out (result word)
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in (register write)
//
// An out-of-square request skips the slot memory. A miss that brings a tile in is paced
// by the nine reads and up to five writes of the single-port slot memory, with one more
// step for a save. After reset a clearing pass over all 4096 slots runs; requests are
// held off meanwhile.
// A two-word queue parts the request side from the sequencer, and the output
// register lets the sequencer stall only when a result cannot be placed.
module direct_mapped_tile_cache_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  dmtc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output dmtc_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic           cfg_data
);

	dmtc_pkg::cfg_t  cfg_q;
	logic            clearing, q_valid, q_pop;
	dmtc_pkg::qent_t q_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{finite_world: 1'b0, storage_present: 1'b0, generator_present: 1'b1};
		end else if (cfg_valid) begin
			case (cfg_index)
				dmtc_pkg::CFG_FINITE:  cfg_q.finite_world      <= cfg_data;
				dmtc_pkg::CFG_STORAGE: cfg_q.storage_present   <= cfg_data;
				dmtc_pkg::CFG_GEN:     cfg_q.generator_present <= cfg_data;
				default: ;
			endcase
		end
	end

	dmtc_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .clearing,
		.req_valid, .req_ready, .req,
		.q_valid, .q_data, .q_pop
	);

	dmtc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .clearing,
		.q_valid, .q_data, .q_pop,
		.rsp_valid, .rsp_ready, .rsp
	);

endmodule

// ----- sim/direct_mapped_tile_cache_unit_tb.sv -----
// Testbench for direct_mapped_tile_cache_unit: directed table then random requests,
// every result word checked against an in-bench model of the slot store.
// Depends on dmtc_pkg and the RTL top level only.
module direct_mapped_tile_cache_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IMASK = (1 << dmtc_pkg::INDEX_BITS) - 1;
	localparam int LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	dmtc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	dmtc_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	direct_mapped_tile_cache_unit dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model copy of the slot store and registers
	logic m_finite, m_storage, m_gen;
	logic s_valid [dmtc_pkg::SLOTS];
	logic s_dec [dmtc_pkg::SLOTS];
	logic [31:0] s_tx [dmtc_pkg::SLOTS];
	logic [31:0] s_tz [dmtc_pkg::SLOTS];
	dmtc_pkg::rsp_t expected_words [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int rsp_hold = 0;

	// one directed row: request, registers, and optional typed-in kind
	typedef struct {
		logic [31:0] x, z;
		logic hit, sd;
		logic fin, sto, gen;
		int kind0;
	} row_t;

	task automatic report(input string what, input dmtc_pkg::rsp_t got,
			input dmtc_pkg::rsp_t want);
		mismatches++;
		$display("word mismatch on %s: got k%0d (%0d,%0d) l%0d, want k%0d (%0d,%0d) l%0d",
			what, got.kind, got.out_x, got.out_z, got.last,
			want.kind, want.out_x, want.out_z, want.last);
	endtask

	function automatic int slot_at(input logic [31:0] x, input logic [31:0] z);
		return ((z & IMASK) << dmtc_pkg::INDEX_BITS) | (x & IMASK);
	endfunction

	function automatic logic in_square(input logic [31:0] x, input logic [31:0] z);
		return !m_finite || (x <= 32'(dmtc_pkg::FINITE_EDGE)
			&& z <= 32'(dmtc_pkg::FINITE_EDGE));
	endfunction

	function automatic logic tile_held(input logic [31:0] x, input logic [31:0] z);
		int i;
		i = slot_at(x, z);
		return s_valid[i] && s_tx[i] == (x >> dmtc_pkg::INDEX_BITS)
			&& s_tz[i] == (z >> dmtc_pkg::INDEX_BITS);
	endfunction

	function automatic logic tile_present(input logic [31:0] x, input logic [31:0] z);
		return !in_square(x, z) || tile_held(x, z);
	endfunction

	function automatic void push_word(input logic [2:0] k, input logic [31:0] x,
			input logic [31:0] z);
		dmtc_pkg::rsp_t w;
		w.kind = k;
		w.out_x = x;
		w.out_z = z;
		w.last = 1'b0;
		expected_words.push_back(w);
	endfunction

	function automatic void mark_decorated(input logic [31:0] x, input logic [31:0] z);
		int i;
		if (!in_square(x, z) || !tile_held(x, z))
			return;
		i = slot_at(x, z);
		if (s_dec[i])
			return;
		s_dec[i] = 1'b1;
		if (m_gen)
			push_word(dmtc_pkg::KIND_DECO, x, z);
	endfunction

	// predict the result words of one request and update the store
	function automatic void predict_tile(input dmtc_pkg::req_t r);
		logic [31:0] x, z, xp, xm, zp, zm;
		logic [2:0] k;
		int i;
		x = r.tile_x;
		z = r.tile_z;
		if (!in_square(x, z)) begin
			push_word(dmtc_pkg::KIND_EMPTY, x, z);
		end else if (tile_held(x, z)) begin
			push_word(dmtc_pkg::KIND_HIT, x, z);
		end else begin
			i = slot_at(x, z);
			if (s_valid[i] && m_storage)
				push_word(dmtc_pkg::KIND_SAVE, (s_tx[i] << dmtc_pkg::INDEX_BITS) | (i & IMASK),
					(s_tz[i] << dmtc_pkg::INDEX_BITS) | ((i >> dmtc_pkg::INDEX_BITS) & IMASK));
			if (m_storage && r.storage_hit) begin
				k = dmtc_pkg::KIND_LOAD; s_valid[i] = 1'b1; s_dec[i] = r.stored_decorated;
			end else if (m_gen) begin
				k = dmtc_pkg::KIND_GEN; s_valid[i] = 1'b1; s_dec[i] = 1'b0;
			end else begin
				k = dmtc_pkg::KIND_EMPTY; s_valid[i] = 1'b0; s_dec[i] = 1'b0;
			end
			s_tx[i] = s_valid[i] ? x >> dmtc_pkg::INDEX_BITS : 32'd0;
			s_tz[i] = s_valid[i] ? z >> dmtc_pkg::INDEX_BITS : 32'd0;
			push_word(k, x, z);
			if (s_valid[i]) begin
				xp = x + 1; xm = x - 1; zp = z + 1; zm = z - 1;
				if (!s_dec[i] && tile_present(xp, zp) && tile_present(x, zp)
						&& tile_present(xp, z))
					mark_decorated(x, z);
				if (tile_present(xm, z) && tile_present(xm, zp) && tile_present(x, zp))
					mark_decorated(xm, z);
				if (tile_present(x, zm) && tile_present(xp, zm) && tile_present(xp, z))
					mark_decorated(x, zm);
				if (tile_present(xm, zm) && tile_present(xm, z) && tile_present(x, zm))
					mark_decorated(xm, zm);
			end
		end
		expected_words[$].last = 1'b1;
	endfunction

	// mostly short gaps, a few long; valid drops only for a real gap
	task automatic random_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_tile(input dmtc_pkg::req_t r, input logic gaps);
		if (gaps)
			random_gap();
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_tile(r);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dmtc_pkg::CFG_FINITE:  m_finite = v;
			dmtc_pkg::CFG_STORAGE: m_storage = v;
			default:               m_gen = v;
		endcase
	endtask

	task automatic set_regs(input logic fin, input logic sto, input logic gen);
		wait_drained();
		write_reg(dmtc_pkg::CFG_FINITE, fin);
		write_reg(dmtc_pkg::CFG_STORAGE, sto);
		write_reg(dmtc_pkg::CFG_GEN, gen);
		cfg_valid <= 1'b0;
	endtask

	// result side: compare with oldest expectation
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				report("unexpected word", rsp, rsp);
			end else begin
				if (rsp !== expected_words[0])
					report("result", rsp, expected_words[0]);
				void'(expected_words.pop_front());
			end
		end
	end

	// result side stalls: mostly short, now and then a long one
	always @(posedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ready <= 1'b0;
			rsp_hold <= rsp_hold - 1;
		end else if ($urandom_range(0, 19) == 0) begin
			rsp_ready <= 1'b0;
			rsp_hold <= $urandom_range(10, 40);
		end else begin
			rsp_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// watchdog over cycles with no accepted word (clearing pass included)
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic dmtc_pkg::req_t make_tile(input logic [31:0] x, input logic [31:0] z,
			input logic h, input logic d);
		dmtc_pkg::req_t r;
		r.tile_x = x;
		r.tile_z = z;
		r.storage_hit = h;
		r.stored_decorated = d;
		return r;
	endfunction

	initial begin
		row_t rows [$];
		row_t rw;
		dmtc_pkg::req_t r;
		dmtc_pkg::rsp_t want;
		int bx, bz, n;
		m_finite = 1'b0; m_storage = 1'b0; m_gen = 1'b1;
		for (int i = 0; i < dmtc_pkg::SLOTS; i++) begin
			s_valid[i] = 1'b0; s_dec[i] = 1'b0; s_tx[i] = '0; s_tz[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows: kind typed in where obvious, -1 means predictor only
		rows = '{
			'{32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, dmtc_pkg::KIND_GEN},
			'{32'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, dmtc_pkg::KIND_HIT},
			'{32'd1, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'd0, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'd1, 32'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'h7fffffff, 32'h80000000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'h80000000, 32'h7fffffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'hffffffff, 32'hffffffff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, -1},
			'{32'd64, 32'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, -1},
			'{32'd0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, -1},
			'{32'd128, 32'd64, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, -1},
			'{32'd16, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, dmtc_pkg::KIND_EMPTY},
			'{32'hffffffff, 32'd3, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, dmtc_pkg::KIND_EMPTY},
			'{32'd15, 32'd15, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, -1},
			'{32'd15, 32'd14, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, -1},
			'{32'd14, 32'd15, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, -1},
			'{32'd14, 32'd14, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, -1},
			'{32'd5, 32'd5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, dmtc_pkg::KIND_EMPTY},
			'{32'd3, 32'd3, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, dmtc_pkg::KIND_LOAD},
			'{32'd4, 32'd3, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, -1},
			'{32'd3, 32'd4, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, -1},
			'{32'd4, 32'd4, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, -1},
			'{32'd67, 32'd3, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, -1}
		};
		foreach (rows[j]) begin
			rw = rows[j];
			if (rw.fin !== m_finite || rw.sto !== m_storage || rw.gen !== m_gen)
				set_regs(rw.fin, rw.sto, rw.gen);
			send_tile(make_tile(rw.x, rw.z, rw.hit, rw.sd), 1'b0);
			if (rw.kind0 >= 0) begin
				n = expected_words.size() - 1;
				while (n > 0 && !expected_words[n-1].last)
					n--;
				// a save word comes ahead of the requested tile's word
				if (expected_words[n].kind == dmtc_pkg::KIND_SAVE)
					n++;
				if (expected_words[n].kind != 3'(rw.kind0)) begin
					want = expected_words[n];
					want.kind = 3'(rw.kind0);
					report("directed row kind", expected_words[n], want);
				end
			end
		end

		// random phases through register settings; mostly clustered tiles
		for (int ph = 0; ph < 7; ph++) begin
			set_regs(1'(ph % 2), 1'((ph / 2) % 2), ph != 4);
			bx = $urandom_range(0, 12);
			bz = $urandom_range(0, 12);
			for (int k = 0; k < 27; k++) begin
				case ($urandom_range(0, 9))
					0: r = make_tile($urandom, $urandom, 1'($urandom), 1'($urandom));
					1: r = make_tile(bx + 64 * $urandom_range(0, 2),
						bz + 64 * $urandom_range(0, 2), 1'($urandom), 1'($urandom));
					2: r = make_tile(-$urandom_range(0, 3), -$urandom_range(0, 3),
						1'($urandom), 1'($urandom));
					default: r = make_tile(bx + $urandom_range(0, 4),
						bz + $urandom_range(0, 4), 1'($urandom), 1'($urandom));
				endcase
				send_tile(r, 1'b1);
				// once per phase, let every result drain before the next request
				if (k == 15) begin
					req_valid <= 1'b0;
					do
						@(posedge clk);
					while (expected_words.size() != 0);
				end
			end
		end

		wait_drained();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
